### hw/rtl/thwl_pkg.sv
// Shared constants, types and controller codes for the tagged history loudness core.
package thwl_pkg;

  // Ring geometry
  localparam int HISTORY_DEPTH = 4096;
  localparam int SLOT_W        = $clog2(HISTORY_DEPTH);

  // Field widths
  localparam int FRAME_W  = 48;
  localparam int ENERGY_W = 32;
  localparam int GATE_W   = 17;
  localparam int VALUE_W  = 19;
  localparam int WIN_W    = 13;
  localparam int MAG_W    = ENERGY_W - 1;
  localparam int SUM_W    = WIN_W + MAG_W;
  localparam int DIVN_W   = SUM_W + 1;
  localparam int ITER_W   = 6;

  // Iteration counts of the shared arithmetic
  localparam int DIV_STEPS  = DIVN_W;
  localparam int LOG_FRAC   = 16;
  localparam int SQRT_STEPS = 18;
  localparam int SQRT_X_W   = 2 * SQRT_STEPS;
  localparam int SQRT_REM_W = SQRT_STEPS + 3;

  // Configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Arithmetic constants
  localparam logic signed [18:0] DB_PER_OCTAVE = 19'sd197283;
  localparam logic signed [41:0] OFFSET_Q32    = -42'sd2967822402;
  localparam logic signed [41:0] LOG_ROUND     = 42'sd8388608;
  localparam logic [4:0]         LOG_TOP_EXP   = 5'd30;
  localparam logic signed [5:0]  LOG_Q_SHIFT   = 6'sd28;
  localparam logic signed [VALUE_W-1:0] SILENT_LU = -19'sd51200;
  localparam logic signed [GATE_W-1:0]  GATE_MISS = -17'sd51200;

  // Codes
  localparam logic KIND_PUSH      = 1'b0;
  localparam logic KIND_LOOKUP    = 1'b1;
  localparam logic MODE_LOUDNESS  = 1'b0;
  localparam logic MODE_RMS       = 1'b1;
  localparam logic SEL_MOMENTARY  = 1'b0;
  localparam logic SEL_SHORT_TERM = 1'b1;

  typedef enum logic [1:0] {
    REG_OUTPUT_MODE = 2'd0,
    REG_MOMENTARY   = 2'd1,
    REG_SHORT_TERM  = 2'd2
  } reg_index_t;

  localparam logic             RESET_MODE      = MODE_LOUDNESS;
  localparam logic [WIN_W-1:0] RESET_MOMENTARY = 13'd24;
  localparam logic [WIN_W-1:0] RESET_SHORT     = 13'd180;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LK_RD,
    ST_LK_CMP,
    ST_PUSH_WR,
    ST_WALK_INIT,
    ST_WALK,
    ST_WALK_FLUSH,
    ST_DIV_LOAD,
    ST_DIV,
    ST_CONV_INIT,
    ST_NORM,
    ST_LOG_MUL,
    ST_LOG_UPD,
    ST_LOG_SCALE,
    ST_LOG_RND,
    ST_SQRT,
    ST_SQRT_RND,
    ST_SILENT,
    ST_STORE,
    ST_RES_WR,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic clr;
    logic wr_push;
    logic sel;
    logic walk_init;
    logic walk;
    logic div_load;
    logic div_step;
    logic conv_init;
    logic norm_step;
    logic log_mul;
    logic log_upd;
    logic log_scale;
    logic log_rnd;
    logic sqrt_step;
    logic sqrt_rnd;
    logic silent;
    logic store;
    logic res_wr;
    logic lk_cmp;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic kind;
    logic mode;
    logic clr_last;
    logic walk_last;
    logic div_last;
    logic mean_zero;
    logic norm_done;
    logic log_last;
    logic sqrt_last;
  } status_t;

endpackage

### hw/rtl/thwl_if.sv
// Valid/ready channel interfaces for input items and result items.
interface thwl_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kind;
  logic signed [thwl_pkg::FRAME_W-1:0]  frame_index;
  logic signed [thwl_pkg::ENERGY_W-1:0] energy;
  logic signed [thwl_pkg::GATE_W-1:0]   gate_in;
  logic                                 playing;

  modport source (output valid, kind, frame_index, energy, gate_in, playing, input ready);
  modport sink (input valid, kind, frame_index, energy, gate_in, playing, output ready);
endinterface

interface thwl_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [thwl_pkg::FRAME_W-1:0] index_out;
  logic                                found;
  logic signed [thwl_pkg::VALUE_W-1:0] momentary_out;
  logic signed [thwl_pkg::VALUE_W-1:0] short_term_out;
  logic signed [thwl_pkg::GATE_W-1:0]  gate_out;
  logic                                playing_out;

  modport source (output valid, index_out, found, momentary_out, short_term_out, gate_out,
                  playing_out, input ready);
  modport sink (input valid, index_out, found, momentary_out, short_term_out, gate_out,
                playing_out, output ready);
endinterface

### hw/rtl/thwl_dp.sv
// Datapath: history memories, window walk, serial divider, log and square root units.
module thwl_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  thwl_pkg::cmd_t                       cmd,
  output thwl_pkg::status_t                    stat,
  input  logic                                 in_kind,
  input  logic [thwl_pkg::FRAME_W-1:0]         in_frame,
  input  logic [thwl_pkg::ENERGY_W-1:0]        in_energy,
  input  logic [thwl_pkg::GATE_W-1:0]          in_gate,
  input  logic                                 in_playing,
  input  logic                                 mode,
  input  logic [thwl_pkg::WIN_W-1:0]           momentary_window,
  input  logic [thwl_pkg::WIN_W-1:0]           short_term_window,
  output logic [thwl_pkg::FRAME_W-1:0]         index_out,
  output logic                                 found,
  output logic [thwl_pkg::VALUE_W-1:0]         momentary_out,
  output logic [thwl_pkg::VALUE_W-1:0]         short_term_out,
  output logic [thwl_pkg::GATE_W-1:0]          gate_out,
  output logic                                 playing_out
);
  import thwl_pkg::*;

  // Latched item
  logic               it_kind;
  logic [FRAME_W-1:0] it_frame;
  logic [MAG_W-1:0]   it_energy;
  logic [GATE_W-1:0]  it_gate;
  logic               it_play;
  logic [SLOT_W-1:0]  slot;
  logic               it_minus1;

  // Memories and their registered read data
  logic [MAG_W-1:0]   energy_mem [HISTORY_DEPTH];
  logic [FRAME_W:0]   tag_mem    [HISTORY_DEPTH];
  logic [VALUE_W-1:0] mom_mem    [HISTORY_DEPTH];
  logic [VALUE_W-1:0] short_mem  [HISTORY_DEPTH];
  logic [GATE_W-1:0]  gate_mem   [HISTORY_DEPTH];
  logic [MAG_W-1:0]   rd_energy;
  logic [FRAME_W:0]   rd_tag;
  logic [VALUE_W-1:0] rd_mom;
  logic [VALUE_W-1:0] rd_short;
  logic [GATE_W-1:0]  rd_gate;
  logic [SLOT_W-1:0]  raddr;
  logic [SLOT_W-1:0]  clr_addr;

  // Window walk
  logic [FRAME_W:0]   fcur;
  logic [FRAME_W:0]   fq;
  logic               pv;
  logic [WIN_W-1:0]   wcnt;
  logic [WIN_W-1:0]   w_sel;
  logic [WIN_W-1:0]   w_m1;
  logic               match;
  logic [SUM_W-1:0]   sum;
  logic [WIN_W-1:0]   cnt;

  // Divider
  logic [DIVN_W-1:0]  dn;
  logic [DIVN_W-1:0]  dq;
  logic [WIN_W-1:0]   drem;
  logic [WIN_W:0]     dtrial;
  logic               dge;
  logic [MAG_W-1:0]   mean;
  logic [ITER_W-1:0]  iter;

  // Log and square root
  logic [MAG_W-1:0]      y;
  logic [4:0]            lexp;
  logic [2*MAG_W-1:0]    prod;
  logic [MAG_W:0]        sq;
  logic [LOG_FRAC-1:0]   frac;
  logic signed [5:0]     lint;
  logic signed [21:0]    l2;
  logic signed [40:0]    lprod;
  logic signed [41:0]    tsum;
  logic [SQRT_X_W-1:0]   xs;
  logic [SQRT_REM_W-1:0] sq_rem;
  logic [SQRT_STEPS-1:0] sq_r;
  logic [SQRT_REM_W-1:0] st;
  logic [SQRT_REM_W-1:0] strial;
  logic                  sge;
  logic [VALUE_W-1:0]    cval;
  logic [VALUE_W-1:0]    mval;
  logic [VALUE_W-1:0]    sval;

  // Result fields before the output register
  logic               res_found;
  logic [VALUE_W-1:0] res_mom;
  logic [VALUE_W-1:0] res_short;
  logic [GATE_W-1:0]  res_gate;
  logic               res_play;

  assign slot      = it_frame[SLOT_W-1:0];
  assign it_minus1 = (it_frame == '1);

  // Item latch; negative energies clamp to zero
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_kind   <= in_kind;
      it_frame  <= in_frame;
      it_energy <= in_energy[ENERGY_W-1] ? '0 : in_energy[MAG_W-1:0];
      it_gate   <= in_gate;
      it_play   <= in_playing;
    end
  end

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr) begin
      clr_addr <= clr_addr + SLOT_W'(1);
    end
  end

  // Memory writes
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      tag_mem[clr_addr] <= '0;
    end else if (cmd.wr_push) begin
      tag_mem[slot] <= {!it_minus1, it_frame};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_push) begin
      energy_mem[slot] <= it_energy;
      gate_mem[slot]   <= it_gate;
    end
    if (cmd.res_wr) begin
      mom_mem[slot]   <= mval;
      short_mem[slot] <= sval;
    end
  end

  // Registered reads: walk address while walking, else the item's slot
  assign raddr = cmd.walk ? fcur[SLOT_W-1:0] : slot;

  always_ff @(posedge clk) begin
    rd_energy <= energy_mem[raddr];
    rd_tag    <= tag_mem[raddr];
    rd_mom    <= mom_mem[raddr];
    rd_short  <= short_mem[raddr];
    rd_gate   <= gate_mem[raddr];
  end

  // Window walk over frames end-(w-1) .. end; a zero window counts as one frame
  assign w_sel = (cmd.sel == SEL_SHORT_TERM) ? short_term_window : momentary_window;
  assign w_m1  = (w_sel == '0) ? '0 : w_sel - WIN_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= cmd.walk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      fcur <= {it_frame[FRAME_W-1], it_frame} - {{(FRAME_W+1-WIN_W){1'b0}}, w_m1};
      wcnt <= w_m1;
    end else if (cmd.walk) begin
      fcur <= fcur + (FRAME_W+1)'(1);
      wcnt <= wcnt - WIN_W'(1);
    end
    fq <= fcur;
  end

  // A frame counts when its slot tag matches, it lies in range and is not minus one
  assign match = pv && rd_tag[FRAME_W] && (rd_tag[FRAME_W-1:0] == fq[FRAME_W-1:0]) &&
                 (fq[FRAME_W] == fq[FRAME_W-1]) && (fq[FRAME_W-1:0] != '1);

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      sum <= '0;
      cnt <= '0;
    end else if (match) begin
      sum <= sum + SUM_W'(rd_energy);
      cnt <= cnt + WIN_W'(1);
    end
  end

  // Restoring divider, one quotient bit per cycle, rounding to nearest
  assign dtrial = {drem, dn[DIVN_W-1]};
  assign dge    = (dtrial >= {1'b0, cnt});
  assign mean   = (cnt == '0) ? '0 : dq[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dn   <= DIVN_W'(sum) + DIVN_W'(cnt >> 1);
      dq   <= '0;
      drem <= '0;
    end else if (cmd.div_step) begin
      dn   <= {dn[DIVN_W-2:0], 1'b0};
      dq   <= {dq[DIVN_W-2:0], dge};
      drem <= dge ? WIN_W'(dtrial - {1'b0, cnt}) : dtrial[WIN_W-1:0];
    end
  end

  // Shared iteration counter
  always_ff @(posedge clk) begin
    if (cmd.div_load || cmd.conv_init) begin
      iter <= '0;
    end else if (cmd.div_step || cmd.log_upd || cmd.sqrt_step) begin
      iter <= iter + ITER_W'(1);
    end
  end

  // Log2 by normalisation and repeated squaring of the Q1.30 mantissa
  assign sq   = prod[2*MAG_W-1:MAG_W-1];
  assign lint = $signed({1'b0, lexp}) - LOG_Q_SHIFT;
  assign l2   = $signed({lint, frac});
  assign tsum = $signed({lprod[40], lprod}) + OFFSET_Q32 + LOG_ROUND;

  always_ff @(posedge clk) begin
    if (cmd.conv_init) begin
      y    <= mean;
      lexp <= LOG_TOP_EXP;
      frac <= '0;
    end else if (cmd.norm_step) begin
      y    <= {y[MAG_W-2:0], 1'b0};
      lexp <= lexp - 5'd1;
    end else if (cmd.log_upd) begin
      y    <= sq[MAG_W] ? sq[MAG_W:1] : sq[MAG_W-1:0];
      frac <= {frac[LOG_FRAC-2:0], sq[MAG_W]};
    end
    if (cmd.log_mul) begin
      prod <= y * y;
    end
    if (cmd.log_scale) begin
      lprod <= l2 * DB_PER_OCTAVE;
    end
  end

  // Digit-by-digit square root of 16 * mean
  assign st     = {sq_rem[SQRT_REM_W-3:0], xs[SQRT_X_W-1:SQRT_X_W-2]};
  assign strial = {1'b0, sq_r, 2'b01};
  assign sge    = (st >= strial);

  always_ff @(posedge clk) begin
    if (cmd.conv_init) begin
      xs     <= {1'b0, mean, 4'b0000};
      sq_rem <= '0;
      sq_r   <= '0;
    end else if (cmd.sqrt_step) begin
      xs     <= {xs[SQRT_X_W-3:0], 2'b00};
      sq_rem <= sge ? st - strial : st;
      sq_r   <= {sq_r[SQRT_STEPS-2:0], sge};
    end
  end

  // Converted value and per-window results
  always_ff @(posedge clk) begin
    if (cmd.log_rnd) begin
      cval <= {tsum[41], tsum[41:24]};
    end else if (cmd.sqrt_rnd) begin
      cval <= {1'b0, sq_r} + VALUE_W'(sq_rem > SQRT_REM_W'(sq_r));
    end else if (cmd.silent) begin
      cval <= SILENT_LU;
    end
    if (cmd.store) begin
      if (cmd.sel == SEL_SHORT_TERM) begin
        sval <= cval;
      end else begin
        mval <= cval;
      end
    end
  end

  // Result fields for a push or a lookup
  always_ff @(posedge clk) begin
    if (cmd.res_wr) begin
      res_found <= 1'b1;
      res_mom   <= mval;
      res_short <= sval;
      res_gate  <= it_gate;
      res_play  <= it_play;
    end else if (cmd.lk_cmp) begin
      res_play <= 1'b0;
      if (rd_tag[FRAME_W] && (rd_tag[FRAME_W-1:0] == it_frame) && !it_minus1) begin
        res_found <= 1'b1;
        res_mom   <= rd_mom;
        res_short <= rd_short;
        res_gate  <= rd_gate;
      end else begin
        res_found <= 1'b0;
        res_mom   <= '0;
        res_short <= '0;
        res_gate  <= GATE_MISS;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      index_out      <= it_frame;
      found          <= res_found;
      momentary_out  <= res_mom;
      short_term_out <= res_short;
      gate_out       <= res_gate;
      playing_out    <= res_play;
    end
  end

  // Status back to the controller
  always_comb begin
    stat.kind      = it_kind;
    stat.mode      = mode;
    stat.clr_last  = (clr_addr == '1);
    stat.walk_last = (wcnt == '0);
    stat.div_last  = (iter == ITER_W'(DIV_STEPS - 1));
    stat.mean_zero = (mean == '0);
    stat.norm_done = y[MAG_W-1];
    stat.log_last  = (iter == ITER_W'(LOG_FRAC - 1));
    stat.sqrt_last = (iter == ITER_W'(SQRT_STEPS - 1));
  end

endmodule

### hw/rtl/thwl_ctrl.sv
// Controller: sequences clearing, lookups, or window walks, division and conversion.
module thwl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  thwl_pkg::status_t stat,
  output thwl_pkg::cmd_t    cmd
);
  import thwl_pkg::*;

  state_t state;
  state_t state_next;
  logic   sel;
  logic   sel_next;
  logic   out_valid_next;

  // State, window select and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sel       <= SEL_MOMENTARY;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sel       <= sel_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    sel_next   = sel;
    cmd        = '0;
    cmd.sel    = sel;
    in_ready   = (state == ST_IDLE);
    case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          sel_next   = SEL_MOMENTARY;
          state_next = ST_LK_RD;
        end
      end
      ST_LK_RD: begin
        state_next = (stat.kind == KIND_LOOKUP) ? ST_LK_CMP : ST_PUSH_WR;
      end
      ST_LK_CMP: begin
        cmd.lk_cmp = 1'b1;
        state_next = ST_FINISH;
      end
      ST_PUSH_WR: begin
        cmd.wr_push = 1'b1;
        state_next  = ST_WALK_INIT;
      end
      ST_WALK_INIT: begin
        cmd.walk_init = 1'b1;
        state_next    = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_last) begin
          state_next = ST_WALK_FLUSH;
        end
      end
      ST_WALK_FLUSH: begin
        state_next = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_CONV_INIT;
        end
      end
      ST_CONV_INIT: begin
        cmd.conv_init = 1'b1;
        if (stat.mode == MODE_RMS) begin
          state_next = ST_SQRT;
        end else if (stat.mean_zero) begin
          state_next = ST_SILENT;
        end else begin
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        if (stat.norm_done) begin
          state_next = ST_LOG_MUL;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      ST_LOG_MUL: begin
        cmd.log_mul = 1'b1;
        state_next  = ST_LOG_UPD;
      end
      ST_LOG_UPD: begin
        cmd.log_upd = 1'b1;
        state_next  = stat.log_last ? ST_LOG_SCALE : ST_LOG_MUL;
      end
      ST_LOG_SCALE: begin
        cmd.log_scale = 1'b1;
        state_next    = ST_LOG_RND;
      end
      ST_LOG_RND: begin
        cmd.log_rnd = 1'b1;
        state_next  = ST_STORE;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_last) begin
          state_next = ST_SQRT_RND;
        end
      end
      ST_SQRT_RND: begin
        cmd.sqrt_rnd = 1'b1;
        state_next   = ST_STORE;
      end
      ST_SILENT: begin
        cmd.silent = 1'b1;
        state_next = ST_STORE;
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (sel == SEL_MOMENTARY) begin
          sel_next   = SEL_SHORT_TERM;
          state_next = ST_WALK_INIT;
        end else begin
          state_next = ST_RES_WR;
        end
      end
      ST_RES_WR: begin
        cmd.res_wr = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The output register holds its item until taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

### hw/rtl/tagged_history_window_loudness_core.sv
// A lookup reads its slot tag in LK_RD, compares in LK_CMP and loads the output in FINISH.
// Each window walk reads one history slot per cycle through the shared read address.
// Per window a push runs the serial divider, then the log or the root, then the store.
// One item at a time: the next item is taken the cycle after the result is registered,
// and a finished item waits in FINISH while the result register is still full.
// Reset: synchronous; afterwards a clearing pass empties the tags of all 4096 slots.
module tagged_history_window_loudness_core (
  input  logic                            clk,
  input  logic                            rst,
  thwl_in_if.sink                         item_in,
  thwl_out_if.source                      result_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [thwl_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [thwl_pkg::APB_DATA_W-1:0] pwdata,
  output logic [thwl_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import thwl_pkg::*;

  logic             output_mode;
  logic [WIN_W-1:0] momentary_window;
  logic [WIN_W-1:0] short_term_window;
  logic             cfg_write;
  cmd_t             cmd;
  status_t          stat;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_mode       <= RESET_MODE;
      momentary_window  <= RESET_MOMENTARY;
      short_term_window <= RESET_SHORT;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_OUTPUT_MODE: output_mode       <= pwdata[0];
        REG_MOMENTARY:   momentary_window  <= pwdata[WIN_W-1:0];
        REG_SHORT_TERM:  short_term_window <= pwdata[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (paddr[3:2])
      REG_OUTPUT_MODE: prdata = {{(APB_DATA_W-1){1'b0}}, output_mode};
      REG_MOMENTARY:   prdata = {{(APB_DATA_W-WIN_W){1'b0}}, momentary_window};
      REG_SHORT_TERM:  prdata = {{(APB_DATA_W-WIN_W){1'b0}}, short_term_window};
      default:         prdata = '0;
    endcase
  end

  // Controller
  thwl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_in.valid),
    .in_ready  (item_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath
  thwl_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .in_kind           (item_in.kind),
    .in_frame          (item_in.frame_index),
    .in_energy         (item_in.energy),
    .in_gate           (item_in.gate_in),
    .in_playing        (item_in.playing),
    .mode              (output_mode),
    .momentary_window  (momentary_window),
    .short_term_window (short_term_window),
    .index_out         (result_out.index_out),
    .found             (result_out.found),
    .momentary_out     (result_out.momentary_out),
    .short_term_out    (result_out.short_term_out),
    .gate_out          (result_out.gate_out),
    .playing_out       (result_out.playing_out)
  );

endmodule
